// ===== hw/rtl/tigs_pkg.sv =====
package tigs_pkg;

  // default sizes
  localparam int unsigned GRID_DEPTH_DEF = 32;
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned EntryIdxW  = 5;
  localparam int unsigned GridCountW = 6;
  localparam int unsigned TolW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_GRID_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE  = 2'd1;

  // reset values of the configuration registers
  localparam logic [GridCountW-1:0] GRID_COUNT_RST = 6'd1;
  localparam logic [TolW-1:0]       TOLERANCE_RST  = 16'd7;

  // item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SPLIT = 1'b1;

  // result status codes
  localparam logic ST_OK           = 1'b0;
  localparam logic ST_BAD_INTERVAL = 1'b1;

endpackage

// ===== hw/rtl/tigs_in_if.sv =====
interface tigs_in_if #(
  parameter int unsigned TIME_WIDTH = tigs_pkg::TIME_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [tigs_pkg::EntryIdxW-1:0]   entry_index;
  logic signed [TIME_WIDTH-1:0]     entry_value;
  logic signed [TIME_WIDTH-1:0]     interval_begin;
  logic signed [TIME_WIDTH-1:0]     interval_finish;
  logic                             event_in;

  modport source (
    output valid, action, entry_index, entry_value, interval_begin, interval_finish, event_in,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, entry_value, interval_begin, interval_finish, event_in,
    output ready
  );
endinterface

// ===== hw/rtl/tigs_out_if.sv =====
interface tigs_out_if #(
  parameter int unsigned TIME_WIDTH = tigs_pkg::TIME_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [TIME_WIDTH-1:0] piece_start;
  logic [TIME_WIDTH-1:0]        piece_length;
  logic                         event_out;
  logic                         last_piece;
  logic                         status;

  modport source (
    output valid, piece_start, piece_length, event_out, last_piece, status,
    input  ready
  );
  modport sink (
    input  valid, piece_start, piece_length, event_out, last_piece, status,
    output ready
  );
endinterface

// ===== hw/rtl/tigs_cfg_if.sv =====
interface tigs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tigs_pkg::CfgIdxW-1:0]   index;
  logic [tigs_pkg::CfgDataW-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== hw/rtl/time_interval_grid_splitter_top.sv =====
// load item: no result, next item can follow at once
// bad interval: error result via the S_BAD state and the output register; next item once it is loaded
// split item: a floor search scan (S_BEST), then a cut scan (S_SPLIT), both through the single
//   read port, then the closing piece (S_LAST); output stalls hold the cut scan and the closing
//   piece; the next item is accepted once the closing piece is loaded
// reset: control registers cleared and configuration registers set to their defaults at once
//   (asynchronous, active low); the grid memory holds nothing defined until loaded
module time_interval_grid_splitter_top #(
  parameter int unsigned GRID_DEPTH = tigs_pkg::GRID_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH = tigs_pkg::TIME_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tigs_in_if.sink           in_i,
  tigs_out_if.source        out_o,
  tigs_cfg_if.sink          cfg_i
);

  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned AddrW = $clog2(GRID_DEPTH);
  localparam int unsigned CntW  = $clog2(GRID_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BAD   = 3'd1;
  localparam logic [2:0] S_BEST  = 3'd2;
  localparam logic [2:0] S_SPLIT = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration registers
  logic [tigs_pkg::GridCountW-1:0] grid_count_q;
  logic [tigs_pkg::TolW-1:0]       tol_q;

  // interval under work
  logic signed [TW-1:0] b_q, f_q;
  logic                 ev_q;

  // scan state
  logic [CntW-1:0]      rd_cnt_q, rd_cnt_d;
  logic                 dv_q, dv_d;
  logic signed [TW-1:0] best_q, best_d;
  logic                 best_ok_q, best_ok_d;
  logic                 found_q, found_d;
  logic signed [TW-1:0] prev_q, prev_d;
  logic                 have_prev_q, have_prev_d;

  // grid memory
  logic [TW-1:0]    grid_mem [GRID_DEPTH];
  logic [TW-1:0]    rd_data_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr;

  // output register
  logic                 out_valid_q;
  logic signed [TW-1:0] out_start_q, out_start_d;
  logic [TW-1:0]        out_len_q, out_len_d;
  logic                 out_ev_q, out_ev_d;
  logic                 out_last_q, out_last_d;
  logic                 out_status_q, out_status_d;
  logic                 out_load;
  logic                 slot_free;

  logic                 in_fire;
  logic [CntW-1:0]      n_eff;
  logic [tigs_pkg::TolW-1:0] te;
  logic signed [TW-1:0] p;
  logic signed [TW:0]   d_pb, d_fp, te_x;
  logic                 pt_ok;
  logic                 stall;
  logic signed [TW-1:0] from_v;

  assign in_fire   = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;

  // handshakes, configuration only between items and only while no item is offered
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = (state_q == S_IDLE) && !in_i.valid;

  // active grid size, zero counts as one, clamped to the depth
  always_comb begin
    if (grid_count_q == '0) begin
      n_eff = CntW'(1);
    end else if (grid_count_q > tigs_pkg::GridCountW'(GRID_DEPTH)) begin
      n_eff = CntW'(GRID_DEPTH);
    end else begin
      n_eff = grid_count_q[CntW-1:0];
    end
  end

  // zero tolerance still demands a strict difference
  assign te   = (tol_q == '0) ? tigs_pkg::TolW'(1) : tol_q;
  assign te_x = $signed({{(TW + 1 - tigs_pkg::TolW){1'b0}}, te});

  // interior point test on the entry in the read register
  assign p     = $signed(rd_data_q);
  assign d_pb  = $signed({p[TW-1], p}) - $signed({b_q[TW-1], b_q});
  assign d_fp  = $signed({f_q[TW-1], f_q}) - $signed({p[TW-1], p});
  assign pt_ok = (d_pb >= te_x) && (d_fp >= te_x) && (!have_prev_q || (p > prev_q));
  assign stall = (state_q == S_SPLIT) && dv_q && pt_ok && !slot_free;

  // start of the current piece's measured span
  assign from_v = have_prev_q ? prev_q : b_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_count_q <= tigs_pkg::GRID_COUNT_RST;
      tol_q        <= tigs_pkg::TOLERANCE_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        tigs_pkg::CFG_GRID_COUNT: grid_count_q <= cfg_i.data[tigs_pkg::GridCountW-1:0];
        tigs_pkg::CFG_TOLERANCE:  tol_q        <= cfg_i.data[tigs_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    rd_cnt_d     = rd_cnt_q;
    dv_d         = dv_q;
    best_d       = best_q;
    best_ok_d    = best_ok_q;
    found_d      = found_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = AddrW'(in_i.entry_index);
    out_load     = 1'b0;
    out_start_d  = '0;
    out_len_d    = '0;
    out_ev_d     = 1'b0;
    out_last_d   = 1'b0;
    out_status_d = tigs_pkg::ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.action == tigs_pkg::ACT_LOAD) begin
            // out-of-range indexes are dropped
            mem_we = (tigs_pkg::GridCountW'(in_i.entry_index)
                      < tigs_pkg::GridCountW'(GRID_DEPTH));
          end else if (in_i.interval_finish <= in_i.interval_begin) begin
            state_d = S_BAD;
          end else begin
            state_d     = S_BEST;
            rd_cnt_d    = '0;
            dv_d        = 1'b0;
            found_d     = 1'b0;
            best_ok_d   = 1'b0;
            have_prev_d = 1'b0;
          end
        end
      end

      S_BAD: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_last_d   = 1'b1;
          out_status_d = tigs_pkg::ST_BAD_INTERVAL;
          state_d      = S_IDLE;
        end
      end

      // first pass: greatest entry at or below the start, entry 0 otherwise
      S_BEST: begin
        mem_re = (rd_cnt_q < n_eff);
        if (mem_re) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end
        dv_d = mem_re;
        if (dv_q) begin
          if (!best_ok_q) begin
            best_d    = p;
            best_ok_d = 1'b1;
            found_d   = (p <= b_q);
          end else if ((p <= b_q) && (!found_q || (p > best_q))) begin
            best_d  = p;
            found_d = 1'b1;
          end
        end
        if ((rd_cnt_q == n_eff) && !dv_q) begin
          state_d  = S_SPLIT;
          rd_cnt_d = '0;
          dv_d     = 1'b0;
        end
      end

      // second pass: one piece per accepted interior point
      S_SPLIT: begin
        mem_re = !stall && (rd_cnt_q < n_eff);
        if (mem_re) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end
        dv_d = stall ? 1'b1 : mem_re;
        if (dv_q && pt_ok && !stall) begin
          out_load    = 1'b1;
          out_start_d = have_prev_q ? prev_q : best_q;
          out_len_d   = p - from_v;
          prev_d      = p;
          have_prev_d = 1'b1;
        end
        if ((rd_cnt_q == n_eff) && !dv_q) begin
          state_d = S_LAST;
        end
      end

      // closing piece up to the real end
      S_LAST: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_start_d = have_prev_q ? prev_q : best_q;
          out_len_d   = f_q - from_v;
          out_ev_d    = ev_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      dv_q        <= 1'b0;
      best_ok_q   <= 1'b0;
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      dv_q        <= dv_d;
      best_ok_q   <= best_ok_d;
      found_q     <= found_d;
      have_prev_q <= have_prev_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    prev_q <= prev_d;
    if (in_fire && (in_i.action == tigs_pkg::ACT_SPLIT)) begin
      b_q  <= in_i.interval_begin;
      f_q  <= in_i.interval_finish;
      ev_q <= in_i.event_in;
    end
    if (out_load) begin
      out_start_q  <= out_start_d;
      out_len_q    <= out_len_d;
      out_ev_q     <= out_ev_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
    end
  end

  // grid memory, one write and one registered read per cycle;
  // writes happen only in idle and reads only during a split, so they never meet
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= in_i.entry_value;
    end
    if (mem_re) begin
      rd_data_q <= grid_mem[rd_cnt_q[AddrW-1:0]];
    end
  end

  // result port
  assign out_o.valid        = out_valid_q;
  assign out_o.piece_start  = out_start_q;
  assign out_o.piece_length = out_len_q;
  assign out_o.event_out    = out_ev_q;
  assign out_o.last_piece   = out_last_q;
  assign out_o.status       = out_status_q;

  // read counter never runs past the active grid while scanning
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BEST) || (state_q == S_SPLIT) |-> rd_cnt_q <= n_eff)
    else $error("grid read counter beyond active entries");

  // a stalled point keeps its read data until it is emitted
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> dv_q && $stable(rd_data_q))
    else $error("stalled grid entry lost");

  // every good piece has a nonzero length
  a_len_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (out_status_d == tigs_pkg::ST_OK) |-> out_len_d != '0)
    else $error("zero-length piece");

  // no read data pending once back in idle
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !dv_q)
    else $error("read data pending in idle");

  // a result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("output register overwritten");

endmodule
